FILE: hdl/rcpwm_pkg.sv
// rcpwm_pkg: shared types, constants and helpers of the RC PWM decoder.
// Used by the result and register interfaces, the divider, the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package rcpwm_pkg;

    // Field and register widths fixed by the block definition
    localparam int POS_W      = 16;
    localparam int DZ_W       = 14;
    localparam int TIMEOUT_W  = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TANK_MIX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

    // Configuration reset values
    localparam logic [DZ_W-1:0]      DEADZONE_RST = 14'd819;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 48'd100000000;

    // Pulse width window in ns: floor(ns / 1000) within 800..2200 us
    localparam logic [31:0] WIDTH_MIN_NS = 32'd800000;
    localparam logic [31:0] WIDTH_MAX_NS = 32'd2200999;
    localparam int          WIDTH_NS_W   = 22;

    // Normalization constants
    localparam int               WUS_W        = 12;
    localparam logic [WUS_W-1:0] MID_STICK_US = 12'd1500;
    localparam int               ABSD_W       = 10;
    localparam int               FRAC_W       = 14;

    // ns to us: floor(x / 1000) == (x * ceil(2^30 / 1000)) >> 30 for x below 2^22
    localparam int                    US_RECIP_W = 21;
    localparam logic [US_RECIP_W-1:0] US_RECIP   = 21'd1073742;
    localparam int                    US_SHIFT   = 30;

    // us offset to Q2.14: floor(d * 16384 / 500) == (d * ceil(2^30 / 125)) >> 18
    // for d up to 700
    localparam int                     RAW_RECIP_W = 24;
    localparam logic [RAW_RECIP_W-1:0] RAW_RECIP   = 24'd8589935;
    localparam int                     RAW_SHIFT   = 18;

    // Divider geometry for the deadzone rescale
    localparam int DIV_NUM_W = 29;
    localparam int DIV_DEN_W = 15;

    localparam logic [DIV_DEN_W-1:0] ONE_Q14 = 15'd16384;

    // Controller to datapath commands
    typedef struct packed {
        logic     take;        // latch the input word
        logic     set_rise;    // store rise time, mark valid
        logic     clr_rise;    // drop the stored rise
        logic     diff_rise;   // diff = time - rise_time[chan]
        logic     diff_age;    // diff = time - last_pulse[age_ch]
        logic     age_ch;
        logic     calc_width;  // latch the width in us
        logic     calc_raw;    // latch the clamped raw magnitude and sign
        logic     div_start;
        logic     write_pos;   // store position, pulse time, seen flag
        logic     pos_zero;    // position inside the deadzone
        logic     load_out;    // fill the output register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_sample;
        logic is_rising;
        logic rise_valid;
        logic in_range;
        logic div_done;
        logic below_dz;
        logic seen_both;
        logic age_ok;
        logic out_free;
    } dp_status_t;

    // Clamp a widened Q2.14 sum to plus or minus one
    function automatic logic signed [POS_W-1:0] clamp_q14(input logic signed [POS_W:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 17'sd16384)
        begin
            r = 16'sd16384;
        end
        else if (v < -17'sd16384)
        begin
            r = -16'sd16384;
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/rcpwm_in_if.sv
// rcpwm_in_if: input channel carrying edge events and sample requests.
// Depends on nothing; width of the timestamp set by TIME_BITS.
`timescale 1ns / 1ps

interface rcpwm_in_if #(parameter int TIME_BITS = 48);
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic                 chan;
    logic                 rising;
    logic [TIME_BITS-1:0] time_ns;

    modport source (output valid, cmd, chan, rising, time_ns, input ready);
    modport sink   (input valid, cmd, chan, rising, time_ns, output ready);
endinterface

FILE: hdl/rcpwm_out_if.sv
// rcpwm_out_if: result channel carrying steering and throttle in Q2.14.
// Depends on rcpwm_pkg.
`timescale 1ns / 1ps

interface rcpwm_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rcpwm_pkg::POS_W-1:0]   steering;
    logic signed [rcpwm_pkg::POS_W-1:0]   throttle;

    modport source (output valid, steering, throttle, input ready);
    modport sink   (input valid, steering, throttle, output ready);
endinterface

FILE: hdl/rcpwm_cfg_if.sv
// rcpwm_cfg_if: configuration write channel, register index and data.
// Depends on rcpwm_pkg.
`timescale 1ns / 1ps

interface rcpwm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [rcpwm_pkg::CFG_IDX_W-1:0]     index;
    logic [rcpwm_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/rcpwm_div.sv
// rcpwm_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on rcpwm_pkg for operand widths.
`timescale 1ns / 1ps

module rcpwm_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [rcpwm_pkg::DIV_NUM_W-1:0]     num,
    input  logic [rcpwm_pkg::DIV_DEN_W-1:0]     den,
    output logic                                busy,
    output logic                                done,
    output logic [rcpwm_pkg::DIV_NUM_W-1:0]     quot
);
    localparam int NW    = rcpwm_pkg::DIV_NUM_W;
    localparam int DW    = rcpwm_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NW);

    logic [NW-1:0]    acc_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DW:0]   trial;
    logic [DW:0]   trial_sub;
    logic          ge;
    logic [DW-1:0] rem_next;

    // Trial subtract of the divisor from the shifted remainder
    assign trial     = {rem_reg, acc_reg[NW-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign ge        = trial >= {1'b0, den_reg};
    assign rem_next  = ge ? trial_sub[DW-1:0] : trial[DW-1:0];

    // Shift numerator bits out and quotient bits in
    always_ff @(posedge clk)
    begin
        if (start) begin
            acc_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            acc_reg <= {acc_reg[NW-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    // Count iterations, flag completion for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = acc_reg;

endmodule

FILE: hdl/rcpwm_ctrl.sv
// rcpwm_ctrl: sequencing state machine of the RC PWM decoder.
// Depends on rcpwm_pkg for the command and status structs.
`timescale 1ns / 1ps

module rcpwm_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  rcpwm_pkg::dp_status_t   status,
    output rcpwm_pkg::dp_cmd_t      cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_RANGE  = 4'd2;
    localparam logic [3:0] S_SCALE  = 4'd3;
    localparam logic [3:0] S_DZ     = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_AGE0   = 4'd6;
    localparam logic [3:0] S_AGE1   = 4'd7;
    localparam logic [3:0] S_LOAD   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and command decode
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.is_sample)
                begin
                    cmd.diff_age = 1'b1;
                    cmd.age_ch   = 1'b0;
                    state_next   = S_AGE0;
                end
                else if (status.is_rising)
                begin
                    cmd.set_rise = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (status.rise_valid)
                begin
                    cmd.diff_rise = 1'b1;
                    cmd.clr_rise  = 1'b1;
                    state_next    = S_RANGE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RANGE:
            begin
                if (status.in_range)
                begin
                    cmd.calc_width = 1'b1;
                    state_next     = S_SCALE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCALE:
            begin
                cmd.calc_raw = 1'b1;
                state_next   = S_DZ;
            end
            S_DZ:
            begin
                if (status.below_dz)
                begin
                    cmd.write_pos = 1'b1;
                    cmd.pos_zero  = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.write_pos = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_AGE0:
            begin
                if (status.seen_both && status.age_ok)
                begin
                    cmd.diff_age = 1'b1;
                    cmd.age_ch   = 1'b1;
                    state_next   = S_AGE1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_AGE1:
            begin
                state_next = status.age_ok ? S_LOAD : S_IDLE;
            end
            S_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // A divider completion only lands while a division is awaited
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == S_DIV))
        else $error("divider completion outside the divide state");
`endif

endmodule

FILE: hdl/rcpwm_dp.sv
// rcpwm_dp: datapath of the RC PWM decoder: item latch, per-channel state,
// configuration registers, shared subtractor, divider and output register.
// Depends on rcpwm_pkg and rcpwm_div.
`timescale 1ns / 1ps

module rcpwm_dp #(
    parameter int TIME_BITS = 48
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  rcpwm_pkg::dp_cmd_t                      cmd,
    output rcpwm_pkg::dp_status_t                   status,
    input  logic                                    in_cmd,
    input  logic                                    in_chan,
    input  logic                                    in_rising,
    input  logic [TIME_BITS-1:0]                    in_time_ns,
    input  logic                                    cfg_valid,
    input  logic [rcpwm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rcpwm_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                    out_ready,
    output logic                                    out_valid,
    output logic signed [rcpwm_pkg::POS_W-1:0]      steering,
    output logic signed [rcpwm_pkg::POS_W-1:0]      throttle
);
    localparam int PW    = rcpwm_pkg::POS_W;
    localparam int DZW   = rcpwm_pkg::DZ_W;
    localparam int TOW   = rcpwm_pkg::TIMEOUT_W;
    localparam int NW    = rcpwm_pkg::DIV_NUM_W;
    localparam int DW    = rcpwm_pkg::DIV_DEN_W;
    localparam int WUW   = rcpwm_pkg::WUS_W;
    localparam int ADW   = rcpwm_pkg::ABSD_W;
    localparam int FW    = rcpwm_pkg::FRAC_W;
    localparam int WNW   = rcpwm_pkg::WIDTH_NS_W;
    localparam int WPW   = WNW + rcpwm_pkg::US_RECIP_W;
    localparam int RPW   = ADW + rcpwm_pkg::RAW_RECIP_W;
    localparam int CMP_W = (TIME_BITS > TOW) ? TIME_BITS : TOW;

    // Latched input word
    logic                 cmd_reg;
    logic                 chan_reg;
    logic                 rising_reg;
    logic [TIME_BITS-1:0] time_reg;

    // Per-channel state
    logic [TIME_BITS-1:0]   rise_time_reg [2];
    logic [1:0]             rise_valid_reg;
    logic signed [PW-1:0]   pos_reg [2];
    logic [TIME_BITS-1:0]   last_reg [2];
    logic [1:0]             seen_reg;

    // Configuration
    logic [DZW-1:0] dz_reg;
    logic           mix_reg;
    logic [TOW-1:0] timeout_reg;

    // Arithmetic
    logic [TIME_BITS-1:0] diff_reg;
    logic [TIME_BITS-1:0] diff_next;
    logic [TIME_BITS-1:0] sub_b;
    logic                 sign_reg;

    logic          div_busy;
    logic          div_done;
    logic [NW-1:0] quot;
    logic [NW-1:0] div_num;
    logic [DW-1:0] div_den;

    logic [WPW-1:0] wus_prod;
    logic [WUW-1:0] wus_reg;
    logic [WUW:0]   d_val;
    logic [WUW:0]   d_abs;
    logic [RPW-1:0] raw_prod;
    logic [DW-1:0]  raw_mag;
    logic [DW-1:0]  mag_clamped;
    logic [DW-1:0]  mag_reg;
    logic [DW-1:0]  mag_minus_dz;
    logic [DW-1:0]  dz_ext;
    logic [DW-1:0]  q15;
    logic signed [PW-1:0] pos_next;

    logic signed [PW:0]   c0_ext;
    logic signed [PW:0]   c1_ext;
    logic signed [PW:0]   mix_sum;
    logic signed [PW:0]   mix_diff;
    logic signed [PW-1:0] steer_next;
    logic signed [PW-1:0] thr_next;

    logic                 out_valid_reg;
    logic signed [PW-1:0] steering_reg;
    logic signed [PW-1:0] throttle_reg;

    // Latch the accepted input word
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            cmd_reg    <= in_cmd;
            chan_reg   <= in_chan;
            rising_reg <= in_rising;
            time_reg   <= in_time_ns;
        end
    end

    // Write configuration registers; unknown indexes drop the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg      <= rcpwm_pkg::DEADZONE_RST;
            mix_reg     <= 1'b0;
            timeout_reg <= rcpwm_pkg::TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rcpwm_pkg::CFG_DEADZONE: dz_reg      <= cfg_data[DZW-1:0];
                rcpwm_pkg::CFG_TANK_MIX: mix_reg     <= cfg_data[0];
                rcpwm_pkg::CFG_TIMEOUT:  timeout_reg <= cfg_data[TOW-1:0];
                default: ;
            endcase
        end
    end

    // Shared subtractor: pulse width or pulse age, modulo the time width
    assign sub_b     = cmd.diff_age ? last_reg[cmd.age_ch] : rise_time_reg[chan_reg];
    assign diff_next = time_reg - sub_b;

    always_ff @(posedge clk)
    begin
        if (cmd.diff_rise || cmd.diff_age)
        begin
            diff_reg <= diff_next;
        end
    end

    // Width in us by reciprocal multiplication, exact over the accepted window
    assign wus_prod = WPW'(diff_reg[WNW-1:0]) * WPW'(rcpwm_pkg::US_RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.calc_width)
        begin
            wus_reg <= wus_prod[rcpwm_pkg::US_SHIFT +: WUW];
        end
    end

    // Width in us minus center, split into sign and magnitude
    assign d_val = {1'b0, wus_reg} - {1'b0, rcpwm_pkg::MID_STICK_US};
    assign d_abs = d_val[WUW] ? (~d_val + 1'b1) : d_val;

    // Raw Q2.14 magnitude by reciprocal multiplication, clamped to one
    assign raw_prod    = RPW'(d_abs[ADW-1:0]) * RPW'(rcpwm_pkg::RAW_RECIP);
    assign raw_mag     = raw_prod[rcpwm_pkg::RAW_SHIFT +: DW];
    assign mag_clamped = (raw_mag > rcpwm_pkg::ONE_Q14) ? rcpwm_pkg::ONE_Q14 : raw_mag;

    // Hold the magnitude and sign of the offset for the deadzone step
    always_ff @(posedge clk)
    begin
        if (cmd.calc_raw)
        begin
            mag_reg  <= mag_clamped;
            sign_reg <= d_val[WUW];
        end
    end

    // Strip the deadzone and rescale the rest to full range
    assign dz_ext       = {1'b0, dz_reg};
    assign mag_minus_dz = mag_reg - dz_ext;
    assign div_num      = {mag_minus_dz, {FW{1'b0}}};
    assign div_den      = rcpwm_pkg::ONE_Q14 - dz_ext;

    rcpwm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (quot)
    );

    // Signed position from the rescaled magnitude
    assign q15 = quot[DW-1:0];
    always_comb
    begin
        if (cmd.pos_zero)
        begin
            pos_next = '0;
        end
        else if (sign_reg)
        begin
            pos_next = PW'(0) - {1'b0, q15};
        end
        else
        begin
            pos_next = {1'b0, q15};
        end
    end

    // Per-channel valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_valid_reg <= '0;
            seen_reg       <= '0;
        end
        else
        begin
            if (cmd.set_rise)
            begin
                rise_valid_reg[chan_reg] <= 1'b1;
            end
            if (cmd.clr_rise)
            begin
                rise_valid_reg[chan_reg] <= 1'b0;
            end
            if (cmd.write_pos)
            begin
                seen_reg[chan_reg] <= 1'b1;
            end
        end
    end

    // Per-channel times and positions
    always_ff @(posedge clk)
    begin
        if (cmd.set_rise)
        begin
            rise_time_reg[chan_reg] <= time_reg;
        end
        if (cmd.write_pos)
        begin
            pos_reg[chan_reg]  <= pos_next;
            last_reg[chan_reg] <= time_reg;
        end
    end

    // Tank mix or straight pass
    assign c0_ext     = {pos_reg[0][PW-1], pos_reg[0]};
    assign c1_ext     = {pos_reg[1][PW-1], pos_reg[1]};
    assign mix_sum    = c0_ext + c1_ext;
    assign mix_diff   = c1_ext - c0_ext;
    assign steer_next = mix_reg ? rcpwm_pkg::clamp_q14(mix_diff) : pos_reg[0];
    assign thr_next   = mix_reg ? rcpwm_pkg::clamp_q14(mix_sum)  : pos_reg[1];

    // Output register, drained by the receiver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            steering_reg <= steer_next;
            throttle_reg <= thr_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign steering  = steering_reg;
    assign throttle  = throttle_reg;

    // Status back to the controller
    assign status.is_sample  = cmd_reg;
    assign status.is_rising  = rising_reg;
    assign status.rise_valid = rise_valid_reg[chan_reg];
    assign status.in_range   = (diff_reg >= TIME_BITS'(rcpwm_pkg::WIDTH_MIN_NS)) &&
                               (diff_reg <= TIME_BITS'(rcpwm_pkg::WIDTH_MAX_NS));
    assign status.div_done   = div_done;
    assign status.below_dz   = mag_reg < dz_ext;
    assign status.seen_both  = seen_reg[0] && seen_reg[1];
    assign status.age_ok     = CMP_W'(diff_reg) <= CMP_W'(timeout_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

`ifndef SYNTHESIS
    // Never restart the divider mid-division
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    // Never overwrite a result the receiver has not taken
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    // A stored position marks its channel as seen
    a_seen_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_pos |=> seen_reg[$past(chan_reg)])
        else $error("channel not marked seen after position write");
`endif

endmodule

FILE: hdl/rc_pwm_two_channel_decoder_unit.sv
// rc_pwm_two_channel_decoder_unit: top level of the two-channel RC PWM decoder.
// Depends on rcpwm_pkg, the channel interfaces, rcpwm_ctrl and rcpwm_dp.
`timescale 1ns / 1ps
//
// Usage:
//   in_ch  : valid/ready word of cmd, chan, rising, time_ns. An edge word
//            (cmd 0) updates channel state and gives no result; a sample
//            word (cmd 1) gives one steering/throttle word on out_ch when
//            both channels had an in-window pulse no older than timeout_ns.
//   out_ch : valid/ready word of steering and throttle, signed Q2.14.
//   cfg_ch : register writes, always ready: 0 deadzone, 1 tank_mix,
//            2 timeout_ns; other indexes are dropped. Write only when idle.
// Sequence: one word is in work at a time and in_ch.ready is high only when
//   idle. A rising edge, or a falling edge with no stored rise, passes the
//   decode state only; a falling edge outside the window also the range
//   state. An accepted width then passes scale and deadzone states and, outside
//   the deadzone, the 29-step bit-serial divider of the deadzone rescale.
//   A sample passes decode and the age checks; a reported one then waits in
//   the load state until the output register frees and is registered there.
// Stall: the result sits in an output register, so new words are accepted
//   while it waits; a further sample result waits until that register frees.
// Reset: clears the valid flags, the output register and the configuration
//   to deadzone 819, tank_mix 0, timeout_ns 100000000. No clearing pass.

module rc_pwm_two_channel_decoder_unit #(
    parameter int TIME_BITS = 48
) (
    input  logic            clk,
    input  logic            rst_n,
    rcpwm_in_if.sink        in_ch,
    rcpwm_out_if.source     out_ch,
    rcpwm_cfg_if.sink       cfg_ch
);
    rcpwm_pkg::dp_cmd_t    dp_cmd;
    rcpwm_pkg::dp_status_t dp_status;

    // Configuration writes are always accepted and land in the cycle after
    assign cfg_ch.ready = 1'b1;

    rcpwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    rcpwm_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .status     (dp_status),
        .in_cmd     (in_ch.cmd),
        .in_chan    (in_ch.chan),
        .in_rising  (in_ch.rising),
        .in_time_ns (in_ch.time_ns),
        .cfg_valid  (cfg_ch.valid),
        .cfg_index  (cfg_ch.index),
        .cfg_data   (cfg_ch.data),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .steering   (out_ch.steering),
        .throttle   (out_ch.throttle)
    );

endmodule

FILE: tb/rcpwm_tb_pkg.sv
`timescale 1ns / 1ps
// rcpwm_tb_pkg: codes and widths shared by the decoder testbench files.
// Depends on rcpwm_pkg for the register index width.

package rcpwm_tb_pkg;

    localparam int TB_TIME_W = 48;

    // Input word codes
    localparam logic CMD_EDGE   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;
    localparam logic EDGE_FALL  = 1'b0;
    localparam logic EDGE_RISE  = 1'b1;

    // Register index past the end of the map, dropped by the block
    localparam logic [rcpwm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

endpackage

FILE: tb/rcpwm_axis_checker.sv
`timescale 1ns / 1ps
// rcpwm_axis_checker: watches the input, result and register channels of the
// RC PWM decoder, predicts every steering/throttle word and compares it.
// Depends on rcpwm_pkg, rcpwm_tb_pkg and the three channel interfaces.

module rcpwm_axis_checker
    import rcpwm_pkg::*;
    import rcpwm_tb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rcpwm_in_if  in_ch,
    rcpwm_out_if out_ch,
    rcpwm_cfg_if cfg_ch,
    output int   fail_count,
    output int   axes_pending
);

    localparam int Q14_ONE    = 16384;
    localparam int CENTER_US  = 1500;
    localparam int HALF_US    = 500;
    localparam int MIN_US     = 800;
    localparam int MAX_US     = 2200;
    localparam int NS_IN_US   = 1000;
    localparam int SHOW_LIMIT = 10;

    typedef struct packed {
        logic signed [POS_W-1:0] steering;
        logic signed [POS_W-1:0] throttle;
    } axes_t;

    // Register copy
    logic [DZ_W-1:0]      dz_q;
    logic                 mix_q;
    logic [TB_TIME_W-1:0] timeout_q;

    // Per-channel pulse state
    logic [TB_TIME_W-1:0]    rise_t  [2];
    logic                    rise_ok [2];
    logic signed [POS_W-1:0] pos_q14 [2];
    logic [TB_TIME_W-1:0]    pulse_t [2];
    logic                    seen    [2];

    // Axes words still owed by the block, oldest first
    axes_t axes_due[$];

    function automatic int clamp_unit(input int v);
        if (v > Q14_ONE)
            return Q14_ONE;
        if (v < -Q14_ONE)
            return -Q14_ONE;
        return v;
    endfunction

    // Pulse width in us to Q2.14 position, deadzone cut out and rescaled
    function automatic logic signed [POS_W-1:0] width_to_q14(input int width_us,
                                                             input logic [DZ_W-1:0] dz);
        int raw;
        int mag;
        int dzi;
        int scaled;
        raw = clamp_unit(((width_us - CENTER_US) * Q14_ONE) / HALF_US);
        mag = (raw < 0) ? -raw : raw;
        dzi = int'(dz);
        if (mag < dzi)
            return '0;
        scaled = ((mag - dzi) * Q14_ONE) / (Q14_ONE - dzi);
        return POS_W'((raw < 0) ? -scaled : scaled);
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
            $display("%0t: %s", $time, msg);
    endtask

    // Apply one accepted word to the channel state, queue an axes word if due
    task automatic decode_word(input logic cmd, input logic lane, input logic rising,
                               input logic [TB_TIME_W-1:0] t);
        logic [TB_TIME_W-1:0] wus;
        logic [TB_TIME_W-1:0] age0;
        logic [TB_TIME_W-1:0] age1;
        axes_t                axes;
        if (cmd == CMD_EDGE)
        begin
            if (rising == EDGE_RISE)
            begin
                rise_t[lane]  = t;
                rise_ok[lane] = 1'b1;
            end
            else if (rise_ok[lane])
            begin
                wus = (t - rise_t[lane]) / TB_TIME_W'(NS_IN_US);
                rise_ok[lane] = 1'b0;
                if (wus >= TB_TIME_W'(MIN_US) && wus <= TB_TIME_W'(MAX_US))
                begin
                    pos_q14[lane] = width_to_q14(int'(wus), dz_q);
                    pulse_t[lane] = t;
                    seen[lane]    = 1'b1;
                end
            end
        end
        else
        begin
            age0 = t - pulse_t[0];
            age1 = t - pulse_t[1];
            if (seen[0] && seen[1] && age0 <= timeout_q && age1 <= timeout_q)
            begin
                if (mix_q)
                begin
                    axes.steering = POS_W'(clamp_unit(int'(pos_q14[1]) - int'(pos_q14[0])));
                    axes.throttle = POS_W'(clamp_unit(int'(pos_q14[0]) + int'(pos_q14[1])));
                end
                else
                begin
                    axes.steering = pos_q14[0];
                    axes.throttle = pos_q14[1];
                end
                axes_due.push_back(axes);
            end
        end
    endtask

    // Compare returned words first, then take register writes and new words
    always @(posedge clk or negedge rst_n)
    begin
        axes_t want;
        if (!rst_n)
        begin
            dz_q       = DEADZONE_RST;
            mix_q      = 1'b0;
            timeout_q  = TIMEOUT_RST;
            fail_count = 0;
            for (int i = 0; i < 2; i++)
            begin
                rise_t[i]  = '0;
                rise_ok[i] = 1'b0;
                pos_q14[i] = '0;
                pulse_t[i] = '0;
                seen[i]    = 1'b0;
            end
            axes_due.delete();
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (axes_due.size() == 0)
                    flag_error($sformatf("unexpected word, steering %0d throttle %0d",
                                         out_ch.steering, out_ch.throttle));
                else
                begin
                    want = axes_due.pop_front();
                    if (out_ch.steering !== want.steering)
                        flag_error($sformatf("steering expected %0d, got %0d",
                                             want.steering, out_ch.steering));
                    if (out_ch.throttle !== want.throttle)
                        flag_error($sformatf("throttle expected %0d, got %0d",
                                             want.throttle, out_ch.throttle));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    CFG_DEADZONE: dz_q      = cfg_ch.data[DZ_W-1:0];
                    CFG_TANK_MIX: mix_q     = cfg_ch.data[0];
                    CFG_TIMEOUT:  timeout_q = cfg_ch.data[TIMEOUT_W-1:0];
                    default:      ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                decode_word(in_ch.cmd, in_ch.chan, in_ch.rising, in_ch.time_ns);
        end
        axes_pending = axes_due.size();
    end

endmodule

FILE: tb/tb_rc_pwm_two_channel_decoder_unit.sv
`timescale 1ns / 1ps
// tb_rc_pwm_two_channel_decoder_unit: drives edge and sample words and register
// writes into the decoder and gives the verdict; checking is in rcpwm_axis_checker.
// Depends on rcpwm_pkg, rcpwm_tb_pkg, the channel interfaces and the decoder RTL.

module tb_rc_pwm_two_channel_decoder_unit;
    import rcpwm_pkg::*;
    import rcpwm_tb_pkg::*;

    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 155;
    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int BURST_SAMPLES = 24;
    localparam int RUN_LIMIT_NS  = 10_000_000;

    localparam logic [TB_TIME_W-1:0] NEAR_WRAP   = 48'hFFFF_FFF0_0000;
    localparam logic [TB_TIME_W-1:0] TIMEOUT_MAX = '1;

    logic                 clk = 1'b0;
    logic                 rst_n;
    int                   fail_count;
    int                   axes_pending;
    logic [TB_TIME_W-1:0] now_ns;
    bit                   idle_off  = 1'b0;
    int                   hold_ask  = 0;
    int                   hold_done = 0;
    int                   hold_left = 0;

    rcpwm_in_if #(.TIME_BITS(TB_TIME_W)) in_ch ();
    rcpwm_out_if                         out_ch ();
    rcpwm_cfg_if                         cfg_ch ();

    rc_pwm_two_channel_decoder_unit #(.TIME_BITS(TB_TIME_W)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    rcpwm_axis_checker u_axis_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .fail_count   (fail_count),
        .axes_pending (axes_pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stop a hung run
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_ask != hold_done)
            begin
                hold_done = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready = 1'b0;
            end
            else
                out_ch.ready = idle_off || ($urandom_range(0, 99) >= 16);
        end
    end

    function automatic logic [TB_TIME_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Offer one word after an optional gap and hold it until taken
    task automatic send_word(input logic cmd, input logic lane, input logic rising,
                             input logic [TB_TIME_W-1:0] t);
        while (!idle_off && $urandom_range(0, 99) < 16)
            @(negedge clk);
        in_ch.valid   = 1'b1;
        in_ch.cmd     = cmd;
        in_ch.chan    = lane;
        in_ch.rising  = rising;
        in_ch.time_ns = t;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // Rising edge now, falling edge width_ns later; now_ns ends on the fall
    task automatic pulse_on(input logic lane, input int width_ns);
        send_word(CMD_EDGE, lane, EDGE_RISE, now_ns);
        now_ns += TB_TIME_W'(width_ns);
        send_word(CMD_EDGE, lane, EDGE_FALL, now_ns);
    endtask

    // Channel and edge bits are don't-care on a sample, so scramble them
    task automatic sample_at(input logic [TB_TIME_W-1:0] t);
        send_word(CMD_SAMPLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), t);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Wait for every owed word, then let a slow falling edge finish
    task automatic settle();
        wait (axes_pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Pick and write the register set of one phase: fixed in phases 0 to 2, random after
    task automatic program_phase(input int phase);
        logic [DZ_W-1:0]       dz;
        logic                  mix;
        logic [TB_TIME_W-1:0]  limit_ns;
        logic [CFG_DATA_W-1:0] data;
        int                    roll;
        case (phase)
            0:
            begin
                dz       = '0;
                mix      = 1'b0;
                limit_ns = TIMEOUT_MAX;
            end
            1:
            begin
                dz       = '1;
                mix      = 1'b1;
                limit_ns = '0;
            end
            2:
            begin
                dz       = DEADZONE_RST;
                mix      = 1'b0;
                limit_ns = TIMEOUT_RST;
            end
            default:
            begin
                if ($urandom_range(0, 1) == 1)
                    dz = DZ_W'($urandom_range(0, 16383));
                else
                    dz = DZ_W'($urandom_range(0, 2000));
                mix  = 1'($urandom_range(0, 1));
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    limit_ns = TB_TIME_W'($urandom_range(1_000_000, 200_000_000));
                else if (roll < 85)
                    limit_ns = rand48();
                else
                    limit_ns = TB_TIME_W'($urandom_range(0, 5_000_000));
            end
        endcase
        write_reg(CFG_SPARE, rand48());
        // Upper data bits are junk the block must drop
        data           = rand48();
        data[DZ_W-1:0] = dz;
        write_reg(CFG_DEADZONE, data);
        data    = rand48();
        data[0] = mix;
        write_reg(CFG_TANK_MIX, data);
        write_reg(CFG_TIMEOUT, limit_ns);
    endtask

    initial
    begin
        logic [TB_TIME_W-1:0] t_ch0;
        logic [TB_TIME_W-1:0] t_ch1;
        logic [TB_TIME_W-1:0] stray;
        int                   count;
        int                   pick;
        int                   width;

        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.cmd     = CMD_EDGE;
        in_ch.chan    = 1'b0;
        in_ch.rising  = EDGE_FALL;
        in_ch.time_ns = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_DEADZONE;
        cfg_ch.data   = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: no pulse yet, lone fall, repeated rise, fall across the wrap
        now_ns = NEAR_WRAP;
        sample_at(now_ns);
        send_word(CMD_EDGE, 1'b0, EDGE_FALL, now_ns);
        send_word(CMD_EDGE, 1'b0, EDGE_RISE, now_ns);
        now_ns += 1000;
        pulse_on(1'b0, 1_500_000);
        now_ns += 3000;
        pulse_on(1'b1, 2_200_999);
        sample_at(now_ns);

        // Window edges: just short, just long, then the shortest accepted
        now_ns += 3000;
        pulse_on(1'b0, 799_999);
        now_ns += 3000;
        pulse_on(1'b0, 2_201_000);
        now_ns += 3000;
        pulse_on(1'b0, 800_000);
        t_ch0 = now_ns;
        now_ns += 2000;
        pulse_on(1'b1, 1_000_000);
        t_ch1 = now_ns;
        sample_at(now_ns);

        // Age exactly at the limit, one past it, and a pulse lying ahead
        sample_at(t_ch0 + TIMEOUT_RST);
        sample_at(t_ch0 + TIMEOUT_RST + 1);
        sample_at(t_ch1 - 1);

        // Mix with both channels at full scale, then with no deadzone
        settle();
        write_reg(CFG_TANK_MIX, 48'd1);
        write_reg(CFG_DEADZONE, '0);
        sample_at(now_ns);
        now_ns += 3000;
        pulse_on(1'b0, 1_700_000);
        sample_at(now_ns);

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            program_phase(phase);
            idle_off = (phase == 3);
            now_ns   = rand48();
            count    = 0;
            if (phase == 2)
            begin
                // Freeze the result side and keep offering samples
                pulse_on(1'b0, 1_200_000);
                now_ns += 5000;
                pulse_on(1'b1, 1_800_000);
                hold_ask++;
                repeat (BURST_SAMPLES)
                begin
                    now_ns += 1000;
                    sample_at(now_ns);
                end
                count += 4 + BURST_SAMPLES;
            end
            while (count < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    if ($urandom_range(0, 9) == 0)
                        width = $urandom_range(0, 3_000_000);
                    else
                        width = $urandom_range(800_000, 2_200_999);
                    now_ns += TB_TIME_W'($urandom_range(1000, 3_000_000));
                    pulse_on(1'($urandom_range(0, 1)), width);
                    count += 2;
                end
                else if (pick < 85)
                begin
                    // Mostly fresh samples, now and then a long jump that can pass the timeout
                    if ($urandom_range(0, 19) == 0)
                        now_ns += TB_TIME_W'($urandom_range(50_000_000, 300_000_000));
                    else
                        now_ns += TB_TIME_W'($urandom_range(0, 20_000_000));
                    sample_at(now_ns);
                    count++;
                end
                else
                begin
                    // Stray edge, sometimes with a wild timestamp
                    if ($urandom_range(0, 3) == 0)
                        stray = rand48();
                    else
                        stray = now_ns + TB_TIME_W'($urandom_range(0, 2_000_000));
                    send_word(CMD_EDGE, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), stray);
                    count++;
                end
                if ($urandom_range(0, 99) == 0)
                begin
                    wait (axes_pending == 0);
                    @(negedge clk);
                end
            end
        end
        idle_off = 1'b0;

        settle();
        if (fail_count == 0 && axes_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
hdl/rcpwm_pkg.sv
hdl/rcpwm_in_if.sv
hdl/rcpwm_out_if.sv
hdl/rcpwm_cfg_if.sv
hdl/rcpwm_div.sv
hdl/rcpwm_ctrl.sv
hdl/rcpwm_dp.sv
hdl/rc_pwm_two_channel_decoder_unit.sv
tb/rcpwm_tb_pkg.sv
tb/rcpwm_axis_checker.sv
tb/tb_rc_pwm_two_channel_decoder_unit.sv
